[src/mse_pkg.sv]
// Shared types and constants for the merge sort engine.
// Holds the transfer payload structs and the controller state encoding.
// No dependencies.
package mse_pkg;

    // Element width; sets the width of the payload value fields
    localparam int DATA_W = 32;

    // Input payload: one element of the set
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } t_in_item;

    // Output payload: one sorted element
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
        logic                     overflow;
    } t_out_item;

    // Controller states
    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_PASS,
        ST_SEG,
        ST_FETCH_L,
        ST_FETCH_R,
        ST_CAPT_R,
        ST_MERGE,
        ST_REFILL_L,
        ST_REFILL_R,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

endpackage

[src/merge_sort_engine.sv]
// A set of n elements is sorted in ceil(log2 n) merge passes; each merged
// element is written in the merge state and its run head is then refilled
// from the registered buffer read. Each result leaves through a read state and
// a load state; a new set is taken only after the last result is loaded.
// Reset (i_rst_n, synchronous, active low) empties the set and clears overflow;
// buffer contents are left as they are.
module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic              rsel;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;
    logic [DATA_W-1:0] rdata;

    // Sequencer
    mse_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_we_a      (we_a),
        .o_we_b      (we_b),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .o_rsel      (rsel),
        .i_rdata     (rdata)
    );

    // Primary buffer
    mse_ram #(
        .DEPTH (CAPACITY)
    ) u_buf_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    // Merge buffer
    mse_ram #(
        .DEPTH (CAPACITY)
    ) u_buf_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    // Read data from the current source buffer; rsel is stable across the read
    assign rdata = rsel ? rdata_b : rdata_a;

endmodule

[src/mse_ram.sv]
// Simple dual-port buffer: one write port, one read port, registered read data.
// Depends on mse_pkg for the element width.
module mse_ram
    import mse_pkg::*;
#(
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/mse_ctrl.sv]
// Sequencer for the merge sort engine: collects elements, runs bottom-up merge
// passes between two buffers, and streams the result. Depends on mse_pkg.
module mse_ctrl
    import mse_pkg::*;
#(
    parameter int  CAPACITY = 64,
    localparam int ADDR_W   = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int SUM_W    = CNT_W + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    // buffer ports
    output logic              o_we_a,
    output logic              o_we_b,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [DATA_W-1:0] o_wdata,
    output logic [ADDR_W-1:0] o_raddr,
    output logic              o_rsel,
    input  logic [DATA_W-1:0] i_rdata
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_drop, n_drop;
    logic [SUM_W-1:0]         r_width, n_width;
    logic [SUM_W-1:0]         r_lo, n_lo;
    logic [SUM_W-1:0]         r_mid, n_mid;
    logic [SUM_W-1:0]         r_hi, n_hi;
    logic [SUM_W-1:0]         r_i, n_i;
    logic [SUM_W-1:0]         r_j, n_j;
    logic [SUM_W-1:0]         r_k, n_k;
    logic signed [DATA_W-1:0] r_head_l, n_head_l;
    logic signed [DATA_W-1:0] r_head_r, n_head_r;
    logic                     r_src, n_src;
    logic [CNT_W-1:0]         r_emit, n_emit;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_item, n_out_item;

    logic             in_xfer;
    logic             has_room;
    logic             out_free;
    logic [SUM_W-1:0] cnt_ext;
    logic [SUM_W-1:0] lo_w;
    logic [SUM_W-1:0] lo_2w;
    logic [SUM_W-1:0] i_inc;
    logic [SUM_W-1:0] j_inc;
    logic [SUM_W-1:0] k_inc;
    logic             take_l;
    logic             seg_done;
    logic             emit_last;
    logic             set_last;

    // Shared decode
    assign in_xfer   = i_in_valid && (r_state == ST_COLLECT);
    assign has_room  = r_count < CNT_W'(CAPACITY);
    assign out_free  = !r_out_valid || i_out_ready;
    assign cnt_ext   = SUM_W'(r_count);
    assign lo_w      = r_lo + r_width;
    assign lo_2w     = r_lo + (r_width << 1);
    assign i_inc     = r_i + SUM_W'(1);
    assign j_inc     = r_j + SUM_W'(1);
    assign k_inc     = r_k + SUM_W'(1);
    assign set_last  = i_in_item.is_last;
    // Stable merge: left head wins ties
    assign take_l    = (r_i < r_mid) && ((r_j >= r_hi) || !(r_head_r < r_head_l));
    assign seg_done  = (k_inc == r_hi);
    assign emit_last = ((r_emit + CNT_W'(1)) == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: begin
                if (in_xfer && set_last) begin
                    n_state = ST_PASS;
                end
            end
            ST_PASS: begin
                n_state = (r_width < cnt_ext) ? ST_SEG : ST_EMIT_RD;
            end
            ST_SEG:      n_state = ST_FETCH_L;
            ST_FETCH_L:  n_state = ST_FETCH_R;
            ST_FETCH_R:  n_state = ST_CAPT_R;
            ST_CAPT_R:   n_state = ST_MERGE;
            ST_MERGE: begin
                if (seg_done) begin
                    n_state = (lo_2w < cnt_ext) ? ST_SEG : ST_PASS;
                end else begin
                    n_state = take_l ? ST_REFILL_L : ST_REFILL_R;
                end
            end
            ST_REFILL_L: n_state = ST_MERGE;
            ST_REFILL_R: n_state = ST_MERGE;
            ST_EMIT_RD: begin
                if (out_free) begin
                    n_state = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                n_state = emit_last ? ST_COLLECT : ST_EMIT_RD;
            end
            default:     n_state = ST_COLLECT;
        endcase
    end

    // Datapath and buffer controls
    always_comb begin
        n_count     = r_count;
        n_drop      = r_drop;
        n_width     = r_width;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_head_l    = r_head_l;
        n_head_r    = r_head_r;
        n_src       = r_src;
        n_emit      = r_emit;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && !i_out_ready;
        o_we_a      = 1'b0;
        o_we_b      = 1'b0;
        o_waddr     = r_count[ADDR_W-1:0];
        o_wdata     = i_in_item.value;
        o_raddr     = r_i[ADDR_W-1:0];
        o_rsel      = r_src;
        case (r_state)
            ST_COLLECT: begin
                // arrivals land in buffer A in order
                if (in_xfer) begin
                    if (has_room) begin
                        o_we_a  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_width = SUM_W'(1);
                    n_src   = 1'b0;
                end
            end
            ST_PASS: begin
                n_lo   = '0;
                n_emit = '0;
            end
            ST_SEG: begin
                // clip run bounds to the set size
                n_mid = (lo_w < cnt_ext) ? lo_w : cnt_ext;
                n_hi  = (lo_2w < cnt_ext) ? lo_2w : cnt_ext;
                n_i   = r_lo;
                n_j   = (lo_w < cnt_ext) ? lo_w : cnt_ext;
                n_k   = r_lo;
            end
            ST_FETCH_L: begin
                o_raddr = r_i[ADDR_W-1:0];
            end
            ST_FETCH_R: begin
                o_raddr  = r_j[ADDR_W-1:0];
                n_head_l = $signed(i_rdata);
            end
            ST_CAPT_R: begin
                n_head_r = $signed(i_rdata);
            end
            ST_MERGE: begin
                // source and destination are different buffers: no hazard
                o_we_a  = r_src;
                o_we_b  = !r_src;
                o_waddr = r_k[ADDR_W-1:0];
                o_wdata = take_l ? r_head_l : r_head_r;
                n_k     = k_inc;
                if (take_l) begin
                    n_i     = i_inc;
                    o_raddr = i_inc[ADDR_W-1:0];
                end else begin
                    n_j     = j_inc;
                    o_raddr = j_inc[ADDR_W-1:0];
                end
                if (seg_done) begin
                    n_lo = lo_2w;
                    if (!(lo_2w < cnt_ext)) begin
                        n_width = r_width << 1;
                        n_src   = !r_src;
                    end
                end
            end
            ST_REFILL_L: begin
                n_head_l = $signed(i_rdata);
            end
            ST_REFILL_R: begin
                n_head_r = $signed(i_rdata);
            end
            ST_EMIT_RD: begin
                o_raddr = r_emit[ADDR_W-1:0];
            end
            ST_EMIT_LD: begin
                n_out_valid             = 1'b1;
                n_out_item.sorted_value = $signed(i_rdata);
                n_out_item.end_of_set   = emit_last;
                n_out_item.overflow     = r_drop;
                n_emit                  = r_emit + CNT_W'(1);
                if (emit_last) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_width    <= n_width;
        r_lo       <= n_lo;
        r_mid      <= n_mid;
        r_hi       <= n_hi;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_head_l   <= n_head_l;
        r_head_r   <= n_head_r;
        r_src      <= n_src;
        r_emit     <= n_emit;
        r_out_item <= n_out_item;
    end

    assign o_in_ready  = (r_state == ST_COLLECT);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we_a && o_we_b))
        else $error("both buffers written in one cycle");

    a_merge_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> (r_i <= r_mid && r_j <= r_hi && r_k < r_hi))
        else $error("merge index out of run bounds");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_LD) |-> !r_out_valid)
        else $error("result loaded over a pending transfer");

endmodule

[tb/sv/mse_sort_checker.sv]
`timescale 1ns / 1ps
// Checker for the merge sort engine: watches both transfer channels, predicts the
// sorted output of each set and compares every output transfer field by field.
// Depends on mse_pkg for the payload types.
module mse_sort_checker
    import mse_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending
);

    // Elements of the set being collected, in arrival order
    logic signed [DATA_W-1:0] held_elems[$];
    logic                     held_dropped;
    // Sorted results still owed by the engine, oldest first
    t_out_item                sorted_due[$];

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        held_dropped = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns sort check: %s got %h want %h", $time, what, got, want);
        o_errors++;
    endtask

    // Stable ascending sort of the held set; queues one result per element
    task automatic sort_and_queue();
        logic signed [DATA_W-1:0] pick;
        t_out_item                res;
        int                       j;
        for (int i = 1; i < held_elems.size(); i++) begin
            pick = held_elems[i];
            j = i - 1;
            // stopping at an equal value keeps equal values in arrival order
            while (j >= 0) begin
                if (held_elems[j] <= pick) break;
                held_elems[j + 1] = held_elems[j];
                j--;
            end
            held_elems[j + 1] = pick;
        end
        foreach (held_elems[k]) begin
            res.sorted_value = held_elems[k];
            res.end_of_set   = (k == held_elems.size() - 1);
            res.overflow     = held_dropped;
            sorted_due.push_back(res);
        end
        held_elems.delete();
        held_dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            // output transfer: compare against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (sorted_due.size() == 0) begin
                    report_mismatch("unexpected result", 64'(i_out_item), 64'd0);
                end else begin
                    want = sorted_due.pop_front();
                    if (i_out_item.sorted_value !== want.sorted_value)
                        report_mismatch("sorted_value", 64'(i_out_item.sorted_value),
                                        64'(want.sorted_value));
                    if (i_out_item.end_of_set !== want.end_of_set)
                        report_mismatch("end_of_set", 64'(i_out_item.end_of_set),
                                        64'(want.end_of_set));
                    if (i_out_item.overflow !== want.overflow)
                        report_mismatch("overflow", 64'(i_out_item.overflow),
                                        64'(want.overflow));
                end
            end
            // input transfer: store or drop, sort on the marked element
            if (i_in_valid && i_in_ready) begin
                if (held_elems.size() < CAPACITY)
                    held_elems.push_back(i_in_item.value);
                else
                    held_dropped = 1'b1;
                if (i_in_item.is_last)
                    sort_and_queue();
            end
        end
        o_pending = sorted_due.size();
    end

endmodule

[tb/sv/tb_merge_sort_engine.sv]
`timescale 1ns / 1ps
// Testbench top for the merge sort engine: clock, reset, set stimulus and output
// backpressure; the verdict comes from mse_sort_checker. Depends on mse_pkg.
module tb_merge_sort_engine;
    import mse_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int ITEM_TARGET = 470;
    localparam int CALM_AFTER  = 400;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        errors;
    int        pending;
    logic      calm      = 1'b0;
    int        sent      = 0;
    int        stall_left = 0;

    merge_sort_engine #(.CAPACITY(CAPACITY)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    mse_sort_checker #(.CAPACITY(CAPACITY)) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output backpressure: random stall bursts, none once calm
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
            stall_left <= $urandom_range(0, 15);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // One input transfer, with an optional idle burst ahead of it
    task automatic push_element(input logic signed [DATA_W-1:0] val, input logic last);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_item.value   <= val;
        in_item.is_last <= last;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Element values: full range, a narrow band for ties, or extremes
    function automatic logic signed [DATA_W-1:0] pick_value(input int flavor);
        case (flavor)
            0: return $urandom();
            1: return 32'(int'($urandom_range(0, 8)) - 4);
            default: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    3: return '1;
                    4: return 32'sd1;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    initial begin
        logic signed [DATA_W-1:0] mix [7];
        int set_no;
        int set_len;
        int flavor;
        int roll;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // single-element sets at both extremes
        push_element(VAL_MAX, 1'b1);
        push_element(VAL_MIN, 1'b1);
        // extremes mixed with duplicates
        mix = '{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1, VAL_MIN, VAL_MAX};
        foreach (mix[i]) push_element(mix[i], i == 6);
        // already ascending, then strictly descending
        for (int i = 0; i < 4; i++) push_element(32'(i * 1000 - 1500), i == 3);
        for (int i = 0; i < 5; i++) push_element(VAL_MAX - 32'(i), i == 4);

        // random sets; a few hit the capacity limit
        set_no = 0;
        while (sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (set_no == 1)
                set_len = CAPACITY + 1;     // marked element itself dropped
            else if (set_no == 3)
                set_len = CAPACITY;         // exactly full, no drop
            else if (set_no == 5)
                set_len = CAPACITY + 6;     // several dropped
            else if (roll < 3)
                set_len = $urandom_range(CAPACITY - 8, CAPACITY + 8);
            else if (roll < 20)
                set_len = $urandom_range(9, 40);
            else
                set_len = $urandom_range(1, 8);
            flavor = $urandom_range(0, 2);
            for (int i = 0; i < set_len; i++) begin
                calm = (sent >= CALM_AFTER);
                push_element(pick_value(flavor), i == set_len - 1);
            end
            set_no++;
        end
        in_valid <= 1'b0;

        // drain: let the checker see the final transfer, wait for every owed
        // result, then a short settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
